@@ src/assert_macros.svh @@
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SFOD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define SFOD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/sfod_pkg.sv @@
package sfod_pkg;

    // default geometry
    localparam int BANDS_DEF = 32;
    localparam int HIST_DEF  = 64;

    // field widths
    localparam int LevelW   = 12;
    localparam int FluxW    = 29;
    localparam int TimeW    = 32;
    localparam int SensW    = 7;
    localparam int IntW     = 16;
    localparam int StrW     = 9;
    localparam int MultW    = 10;
    localparam int SumW     = 35;
    localparam int SqW      = 64;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    // serial unit widths
    localparam int MulAW   = 64;
    localparam int MulBW   = 36;
    localparam int ProdW   = 72;
    localparam int DivNW   = 72;
    localparam int DivDW   = 32;
    localparam int RootInW = 64;
    localparam int RootW   = 32;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_SENS    = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_INT = 1'd1;

    localparam logic [SensW-1:0] SENS_RESET = 7'd50;
    localparam logic [StrW-1:0]  STR_MIN    = 9'd26;
    localparam logic [StrW-1:0]  STR_MAX    = 9'd256;

    // threshold multiplier in q8: 768 - round(sens * 256 / 40)
    function automatic logic [MultW-1:0] mult_q8(input logic [SensW-1:0] sens);
        logic [SensW-1:0] s;
        logic [14:0]      x;
        logic [11:0]      y;
        logic [25:0]      p;
        s = sens;
        if (s < 7'd1) s = 7'd1;
        if (s > 7'd100) s = 7'd100;
        x = {s, 8'd0} + 15'd20;
        y = x[14:3];
        // divide by five through the reciprocal 13108 / 2^16
        p = 26'(y) * 26'd13108;
        return 10'd768 - 10'(p[25:16]);
    endfunction

endpackage

@@ src/spectral_flux_onset_detector_top.sv @@
// non-final band words are accepted one per cycle, back to back; a frame-closing word
// stalls the input until its result word is loaded, plus any result stall; its length
// is set by the shared bit-serial multiplier (five uses, two while the history is
// empty), divider (three uses, none while the history is empty, plus one when an
// onset is found) and square root unit; one frame in flight; synchronous active-low
// reset clears control state, not data; ring entries beyond the fill read as zero
module spectral_flux_onset_detector_top #(
    parameter int BANDS         = sfod_pkg::BANDS_DEF,
    parameter int HISTORY_DEPTH = sfod_pkg::HIST_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sfod_pkg::LevelW-1:0]    i_band_level,
    input  logic                           i_last_band,
    input  logic [sfod_pkg::TimeW-1:0]     i_frame_time_ms,
    input  logic                           i_detect_enable,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_history_ready,
    output logic                           o_onset_found,
    output logic [sfod_pkg::StrW-1:0]      o_strength_q8,
    output logic [sfod_pkg::TimeW-1:0]     o_gap_ms,
    output logic [sfod_pkg::TimeW-1:0]     o_onset_time_ms,
    output logic [sfod_pkg::FluxW-1:0]     o_candidate_flux,
    output logic [sfod_pkg::TimeW-1:0]     o_flux_threshold,
    input  logic                           i_cfg_we,
    input  logic [sfod_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [sfod_pkg::CfgDataW-1:0]  i_cfg_data
);

    localparam int PosW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int HW    = $clog2(HISTORY_DEPTH);
    localparam int FillW = $clog2(HISTORY_DEPTH + 1);
    localparam int Half  = HISTORY_DEPTH / 2;
    localparam int FluxW = sfod_pkg::FluxW;
    localparam int TimeW = sfod_pkg::TimeW;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OLD_A, ST_OLD_B, ST_OLD_C, ST_PREP, ST_NQ, ST_SS, ST_VAR,
        ST_ROOT, ST_FLOOR, ST_NMD, ST_THR, ST_OLDSQ, ST_NEWSQ,
        ST_WIN_A, ST_WIN_B, ST_WIN_C, ST_EVAL, ST_STR, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [sfod_pkg::SensW-1:0] r_sens;
    logic [sfod_pkg::IntW-1:0]  r_min_int;

    // band front end
    logic [sfod_pkg::LevelW-1:0] r_pb [BANDS];
    logic [BANDS-1:0]            r_pb_vld;
    logic                        r_prior_vld;
    logic [PosW-1:0]             r_pos;
    logic [FluxW-1:0]            r_accum;

    // frame and history state
    logic [FluxW-1:0]           r_flux;
    logic [TimeW-1:0]           r_now;
    logic                       r_en;
    logic [HW-1:0]              r_head;
    logic [FillW-1:0]           r_fill;
    logic [sfod_pkg::SumW-1:0]  r_sum;
    logic [sfod_pkg::SqW-1:0]   r_sq;
    logic [TimeW-1:0]           r_last_time;
    logic                       r_last_vld;

    // ring memories
    logic [FluxW-1:0] r_ring_flux [HISTORY_DEPTH];
    logic [TimeW-1:0] r_ring_time [HISTORY_DEPTH];
    logic             r_ring_en   [HISTORY_DEPTH];
    logic [HW-1:0]    r_raddr;
    logic [FluxW-1:0] r_rd_flux;
    logic [TimeW-1:0] r_rd_time;
    logic             r_rd_en;
    logic             ring_we;

    // frame-end working registers
    logic [FluxW-1:0]           r_old;
    logic [sfod_pkg::ProdW-1:0] r_t1;
    logic [sfod_pkg::RootW-1:0] r_dev;
    logic [TimeW-1:0]           r_thr;
    logic [FluxW-1:0]           r_win [5];
    logic [2:0]                 r_age;
    logic [TimeW-1:0]           r_ctime;
    logic                       r_cen;
    logic                       r_found;
    logic [sfod_pkg::StrW-1:0]  r_str;

    // unit operands
    logic                         r_mul_go;
    logic [sfod_pkg::MulAW-1:0]   r_mul_a;
    logic [sfod_pkg::MulBW-1:0]   r_mul_b;
    logic                         r_div_go;
    logic [sfod_pkg::DivNW-1:0]   r_div_n;
    logic [sfod_pkg::DivDW-1:0]   r_div_d;
    logic                         r_sq_go;
    logic [sfod_pkg::RootInW-1:0] r_sq_v;
    logic                         mul_done;
    logic [sfod_pkg::ProdW-1:0]   mul_prod;
    logic                         div_done;
    logic [sfod_pkg::DivNW-1:0]   div_quot;
    logic                         sq_done;
    logic [sfod_pkg::RootW-1:0]   sq_root;

    // output word
    logic                       r_ovalid;
    logic                       r_o_ready;
    logic                       r_o_found;
    logic [sfod_pkg::StrW-1:0]  r_o_str;
    logic [TimeW-1:0]           r_o_gap;
    logic [TimeW-1:0]           r_o_time;
    logic [FluxW-1:0]           r_o_cand;
    logic [TimeW-1:0]           r_o_thr;

    logic                        in_acc;
    logic [sfod_pkg::LevelW-1:0] prev;
    logic [sfod_pkg::LevelW-1:0] rise;
    logic [23:0]                 rise_sq;
    logic [FluxW:0]              acc_sum;
    logic [FluxW-1:0]            flux_new;
    logic [PosW-1:0]             pos_next;
    logic [sfod_pkg::MultW-1:0]  mult;
    logic [sfod_pkg::ProdW-1:0]  var_num;
    logic [sfod_pkg::RootW-1:0]  dev_max;
    logic [sfod_pkg::ProdW-1:0]  thr_num;
    logic [TimeW-1:0]            thr_sat;
    logic [HW:0]                 idx_tmp;
    logic [HW-1:0]               win_idx;
    logic                        rd_vld;
    logic [TimeW-1:0]            gap;
    logic                        peak;
    logic                        found;
    logic [sfod_pkg::StrW-1:0]   str_clamp;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign mult = sfod_pkg::mult_q8(r_sens);

    // positive rise of the current band, squared and added with saturation
    always_comb begin
        prev     = r_pb_vld[r_pos] ? r_pb[r_pos] : '0;
        rise     = i_band_level - prev;
        rise_sq  = (r_prior_vld && (i_band_level > prev)) ? 24'(rise) * 24'(rise) : '0;
        acc_sum  = (FluxW + 1)'(r_accum) + (FluxW + 1)'(rise_sq);
        flux_new = acc_sum[FluxW] ? '1 : acc_sum[FluxW-1:0];
        pos_next = (r_pos == PosW'(BANDS - 1)) ? '0 : r_pos + 1'b1;
    end

    // threshold arithmetic between serial steps
    always_comb begin
        var_num = (r_t1 >= mul_prod) ? r_t1 - mul_prod : '0;
        dev_max = (r_dev < div_quot[sfod_pkg::RootW-1:0]) ? div_quot[sfod_pkg::RootW-1:0]
                                                          : r_dev;
        thr_num = sfod_pkg::ProdW'({r_sum, 8'd0}) + mul_prod;
        thr_sat = (|div_quot[sfod_pkg::DivNW-1:TimeW]) ? '1 : div_quot[TimeW-1:0];
        if (thr_sat == '0) thr_sat = TimeW'(1);
    end

    // ring address of a frame by age, counted back from the head
    always_comb begin
        idx_tmp = (HW + 1)'(r_head) + (HW + 1)'(HISTORY_DEPTH - 1) - (HW + 1)'(r_age);
        win_idx = (idx_tmp >= (HW + 1)'(HISTORY_DEPTH))
                ? HW'(idx_tmp - (HW + 1)'(HISTORY_DEPTH)) : idx_tmp[HW-1:0];
        rd_vld  = ((FillW + 1)'(r_raddr) < (FillW + 1)'(r_fill));
    end

    // onset decision on the candidate two frames back
    always_comb begin
        gap   = r_ctime - r_last_time;
        peak  = (r_win[0] < r_win[2]) && (r_win[1] < r_win[2]) &&
                (r_win[3] < r_win[2]) && (r_win[4] < r_win[2]);
        found = (r_fill >= FillW'(Half)) && r_cen && peak &&
                (!r_last_vld || (gap >= TimeW'(r_min_int))) &&
                (TimeW'(r_win[2]) > r_thr);
        if ((|div_quot[sfod_pkg::DivNW-1:sfod_pkg::StrW]) ||
            (div_quot[sfod_pkg::StrW-1:0] > sfod_pkg::STR_MAX))
            str_clamp = sfod_pkg::STR_MAX;
        else if (div_quot[sfod_pkg::StrW-1:0] < sfod_pkg::STR_MIN)
            str_clamp = sfod_pkg::STR_MIN;
        else
            str_clamp = div_quot[sfod_pkg::StrW-1:0];
    end

    assign ring_we = (r_state == ST_NEWSQ) && mul_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens    <= sfod_pkg::SENS_RESET;
            r_min_int <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfod_pkg::CFG_SENS:    r_sens    <= i_cfg_data[sfod_pkg::SensW-1:0];
                sfod_pkg::CFG_MIN_INT: r_min_int <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // previous-frame band store
    always_ff @(posedge i_clk) begin
        if (in_acc) r_pb[r_pos] <= i_band_level;
    end

    // history ring, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_flux[r_head] <= r_flux;
            r_ring_time[r_head] <= r_now;
            r_ring_en[r_head]   <= r_en;
        end
        r_rd_flux <= r_ring_flux[r_raddr];
        r_rd_time <= r_ring_time[r_raddr];
        r_rd_en   <= r_ring_en[r_raddr];
    end

    // frame sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pb_vld    <= '0;
            r_prior_vld <= 1'b0;
            r_pos       <= '0;
            r_accum     <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_last_time <= '0;
            r_last_vld  <= 1'b0;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_sq_go     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_pb_vld[r_pos] <= 1'b1;
                        if (i_last_band) begin
                            r_flux      <= flux_new;
                            r_accum     <= '0;
                            r_pos       <= '0;
                            r_prior_vld <= 1'b1;
                            r_now       <= i_frame_time_ms;
                            r_en        <= i_detect_enable;
                            r_state     <= ST_OLD_A;
                        end else begin
                            r_accum <= flux_new;
                            r_pos   <= pos_next;
                        end
                    end
                end
                ST_OLD_A: begin
                    r_raddr <= r_head;
                    r_state <= ST_OLD_B;
                end
                ST_OLD_B: r_state <= ST_OLD_C;
                ST_OLD_C: begin
                    r_old   <= (r_fill == FillW'(HISTORY_DEPTH)) ? r_rd_flux : '0;
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_mul_go <= 1'b1;
                    if (r_fill == '0) begin
                        r_thr   <= TimeW'(1);
                        r_mul_a <= sfod_pkg::MulAW'(r_old);
                        r_mul_b <= sfod_pkg::MulBW'(r_old);
                        r_state <= ST_OLDSQ;
                    end else begin
                        r_mul_a <= r_sq;
                        r_mul_b <= sfod_pkg::MulBW'(r_fill);
                        r_state <= ST_NQ;
                    end
                end
                ST_NQ: begin
                    if (mul_done) begin
                        r_t1     <= mul_prod;
                        r_mul_a  <= sfod_pkg::MulAW'(r_sum);
                        r_mul_b  <= sfod_pkg::MulBW'(r_sum);
                        r_mul_go <= 1'b1;
                        r_state  <= ST_SS;
                    end
                end
                ST_SS: begin
                    if (mul_done) begin
                        r_div_n  <= var_num;
                        r_div_d  <= sfod_pkg::DivDW'(r_fill) * sfod_pkg::DivDW'(r_fill);
                        r_div_go <= 1'b1;
                        r_state  <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    if (div_done) begin
                        r_sq_v  <= div_quot[sfod_pkg::RootInW-1:0];
                        r_sq_go <= 1'b1;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sq_done) begin
                        r_dev    <= sq_root;
                        r_div_n  <= sfod_pkg::DivNW'(r_sum);
                        r_div_d  <= sfod_pkg::DivDW'(r_fill) * sfod_pkg::DivDW'(10);
                        r_div_go <= 1'b1;
                        r_state  <= ST_FLOOR;
                    end
                end
                ST_FLOOR: begin
                    if (div_done) begin
                        r_mul_a  <= sfod_pkg::MulAW'(dev_max);
                        r_mul_b  <= sfod_pkg::MulBW'(r_fill) * sfod_pkg::MulBW'(mult);
                        r_mul_go <= 1'b1;
                        r_state  <= ST_NMD;
                    end
                end
                ST_NMD: begin
                    if (mul_done) begin
                        r_div_n  <= sfod_pkg::DivNW'(thr_num >> 8);
                        r_div_d  <= sfod_pkg::DivDW'(r_fill);
                        r_div_go <= 1'b1;
                        r_state  <= ST_THR;
                    end
                end
                ST_THR: begin
                    if (div_done) begin
                        r_thr    <= thr_sat;
                        r_mul_a  <= sfod_pkg::MulAW'(r_old);
                        r_mul_b  <= sfod_pkg::MulBW'(r_old);
                        r_mul_go <= 1'b1;
                        r_state  <= ST_OLDSQ;
                    end
                end
                ST_OLDSQ: begin
                    if (mul_done) begin
                        r_t1     <= mul_prod;
                        r_mul_a  <= sfod_pkg::MulAW'(r_flux);
                        r_mul_b  <= sfod_pkg::MulBW'(r_flux);
                        r_mul_go <= 1'b1;
                        r_state  <= ST_NEWSQ;
                    end
                end
                ST_NEWSQ: begin
                    if (mul_done) begin
                        r_sum  <= r_sum - sfod_pkg::SumW'(r_old) + sfod_pkg::SumW'(r_flux);
                        r_sq   <= r_sq - r_t1[sfod_pkg::SqW-1:0]
                                + mul_prod[sfod_pkg::SqW-1:0];
                        r_head <= (r_head == HW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        if (r_fill != FillW'(HISTORY_DEPTH)) r_fill <= r_fill + 1'b1;
                        r_age   <= '0;
                        r_state <= ST_WIN_A;
                    end
                end
                ST_WIN_A: begin
                    r_raddr <= win_idx;
                    r_state <= ST_WIN_B;
                end
                ST_WIN_B: r_state <= ST_WIN_C;
                ST_WIN_C: begin
                    r_win[r_age] <= rd_vld ? r_rd_flux : '0;
                    if (r_age == 3'd2) begin
                        r_ctime <= rd_vld ? r_rd_time : '0;
                        r_cen   <= rd_vld && r_rd_en;
                    end
                    if (r_age == 3'd4) begin
                        r_state <= ST_EVAL;
                    end else begin
                        r_age   <= r_age + 1'b1;
                        r_state <= ST_WIN_A;
                    end
                end
                ST_EVAL: begin
                    r_found <= found;
                    if (found) begin
                        r_div_n  <= sfod_pkg::DivNW'({TimeW'(r_win[2]) - r_thr, 8'd0});
                        r_div_d  <= r_thr;
                        r_div_go <= 1'b1;
                        r_state  <= ST_STR;
                    end else begin
                        r_str   <= '0;
                        r_state <= ST_OUT;
                    end
                end
                ST_STR: begin
                    if (div_done) begin
                        r_str   <= str_clamp;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid  <= 1'b1;
                        r_o_ready <= (r_fill >= FillW'(Half));
                        r_o_found <= r_found;
                        r_o_str   <= r_str;
                        r_o_gap   <= (r_found && r_last_vld) ? gap : '0;
                        r_o_time  <= r_found ? r_ctime : '0;
                        r_o_cand  <= r_win[2];
                        r_o_thr   <= r_thr;
                        if (r_found) begin
                            r_last_time <= r_ctime;
                            r_last_vld  <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    sfod_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    sfod_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_n),
        .i_den   (r_div_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    sfod_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_val   (r_sq_v),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_valid          = r_ovalid;
    assign o_history_ready  = r_o_ready;
    assign o_onset_found    = r_o_found;
    assign o_strength_q8    = r_o_str;
    assign o_gap_ms         = r_o_gap;
    assign o_onset_time_ms  = r_o_time;
    assign o_candidate_flux = r_o_cand;
    assign o_flux_threshold = r_o_thr;

    `include "assert_macros.svh"

    // checks
    `SFOD_ASSERT(a_fill_bound, r_fill <= FillW'(HISTORY_DEPTH), "ring fill beyond depth")
    `SFOD_ASSERT_IMP(a_word_src, $rose(r_ovalid), $past(r_state == ST_OUT), "word not from output state")
    `SFOD_ASSERT_IMP(a_str_range, r_ovalid && r_o_found, (r_o_str >= sfod_pkg::STR_MIN) && (r_o_str <= sfod_pkg::STR_MAX), "strength out of range")
    `SFOD_ASSERT_IMP(a_thr_nonzero, r_ovalid, r_o_thr != '0, "zero threshold")

endmodule

@@ src/sfod_mul.sv @@
module sfod_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfod_pkg::MulAW-1:0]  i_a,
    input  logic [sfod_pkg::MulBW-1:0]  i_b,
    output logic                        o_done,
    output logic [sfod_pkg::ProdW-1:0]  o_prod
);

    localparam int CntW = $clog2(sfod_pkg::MulBW);

    logic [sfod_pkg::ProdW-1:0] r_a;
    logic [sfod_pkg::MulBW-1:0] r_b;
    logic [sfod_pkg::ProdW-1:0] r_p;
    logic [CntW-1:0]            r_cnt;
    logic                       r_busy;
    logic                       r_done;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= sfod_pkg::ProdW'(i_a);
                r_b    <= i_b;
                r_p    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) r_p <= r_p + r_a;
                r_a   <= {r_a[sfod_pkg::ProdW-2:0], 1'b0};
                r_b   <= {1'b0, r_b[sfod_pkg::MulBW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(sfod_pkg::MulBW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

@@ src/sfod_div.sv @@
module sfod_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfod_pkg::DivNW-1:0]  i_num,
    input  logic [sfod_pkg::DivDW-1:0]  i_den,
    output logic                        o_done,
    output logic [sfod_pkg::DivNW-1:0]  o_quot
);

    localparam int CntW = $clog2(sfod_pkg::DivNW);

    logic [sfod_pkg::DivNW-1:0] r_q;
    logic [sfod_pkg::DivDW-1:0] r_rem;
    logic [sfod_pkg::DivDW-1:0] r_d;
    logic [CntW-1:0]            r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [sfod_pkg::DivDW:0]   sh;
    logic                       fits;

    // restoring step: bring down one dividend bit
    always_comb begin
        sh   = {r_rem, r_q[sfod_pkg::DivNW-1]};
        fits = (sh >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_d    <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? sfod_pkg::DivDW'(sh - {1'b0, r_d})
                              : sfod_pkg::DivDW'(sh);
                r_q   <= {r_q[sfod_pkg::DivNW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(sfod_pkg::DivNW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ src/sfod_isqrt.sv @@
module sfod_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sfod_pkg::RootInW-1:0]  i_val,
    output logic                          o_done,
    output logic [sfod_pkg::RootW-1:0]    o_root
);

    localparam int Steps = sfod_pkg::RootInW / 2;
    localparam int CntW  = $clog2(Steps);
    localparam int RemW  = sfod_pkg::RootW + 3;

    logic [sfod_pkg::RootInW-1:0] r_v;
    logic [sfod_pkg::RootW-1:0]   r_root;
    logic [RemW-1:0]              r_rem;
    logic [CntW-1:0]              r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [RemW-1:0]              cur;
    logic [RemW-1:0]              trial;
    logic                         fits;

    // one root digit per cycle from two radicand bits
    always_comb begin
        cur   = {r_rem[RemW-3:0], r_v[sfod_pkg::RootInW-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
        fits  = (cur >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_val;
                r_root <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? cur - trial : cur;
                r_root <= {r_root[sfod_pkg::RootW-2:0], fits};
                r_v    <= {r_v[sfod_pkg::RootInW-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CntW'(Steps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ tb/tb_spectral_flux_onset_detector_top.sv @@
`timescale 1ns / 100ps

module tb_spectral_flux_onset_detector_top;

    localparam int NBANDS   = 32;
    localparam int NHIST    = 64;
    localparam int SETTLE   = 700;
    localparam logic [28:0] FLUX_CAP = 29'h1FFF_FFFF;

    // one result word of the block
    typedef struct {
        logic        ready;
        logic        found;
        logic [8:0]  strength;
        logic [31:0] gap;
        logic [31:0] onset_time;
        logic [28:0] cand_flux;
        logic [31:0] threshold;
    } t_onset_word;

    // onset scoreboard: tracks flux history and predicts each frame result
    class t_onset_scoreboard;
        logic [11:0] prior_lvl[NBANDS];
        bit          prior_ok;
        int unsigned band_pos;
        logic [28:0] acc;
        logic [28:0] flux_hist[NHIST];
        logic [31:0] time_hist[NHIST];
        bit          en_hist[NHIST];
        int unsigned head;
        int unsigned fill;
        logic [63:0] flux_tot;
        logic [63:0] flux_sq_tot;
        logic [31:0] last_onset;
        bit          last_onset_ok;
        logic [6:0]  sens;
        logic [15:0] min_gap;
        t_onset_word expected_q[$];
        int          errors;

        function new();
            foreach (prior_lvl[i]) prior_lvl[i] = '0;
            foreach (flux_hist[i]) begin
                flux_hist[i] = '0;
                time_hist[i] = '0;
                en_hist[i]   = 1'b0;
            end
            prior_ok = 0; band_pos = 0; acc = '0; head = 0; fill = 0;
            flux_tot = '0; flux_sq_tot = '0; last_onset = '0; last_onset_ok = 0;
            sens = 7'd50; min_gap = '0; errors = 0;
        endfunction

        function void write_reg(logic [sfod_pkg::CfgIdxW-1:0] idx,
                                logic [sfod_pkg::CfgDataW-1:0] data);
            if (idx == sfod_pkg::CFG_SENS) sens = data[6:0];
            else if (idx == sfod_pkg::CFG_MIN_INT) min_gap = data;
        endfunction

        function logic [63:0] mult_now();
            int unsigned s;
            s = sens;
            if (s < 1) s = 1;
            if (s > 100) s = 100;
            return 64'(768 - (s * 256 + 20) / 40);
        endfunction

        function logic [63:0] root64(logic [63:0] v);
            logic [63:0] res, b;
            res = '0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // adaptive threshold from the history before the push
        function logic [31:0] threshold_now();
            logic [127:0] a, b, r, q;
            logic [63:0]  n, spread, dev, dev_floor, t;
            if (fill == 0) return 32'd1;
            n = 64'(fill);
            a = 128'(n) * 128'(flux_sq_tot);
            b = 128'(flux_tot) * 128'(flux_tot);
            r = (a < b) ? 128'd0 : a - b;
            q = r / 128'(n * n);
            spread = q[63:0];
            dev = root64(spread);
            dev_floor = flux_tot / (64'd10 * n);
            if (dev < dev_floor) dev = dev_floor;
            t = (64'd256 * flux_tot + n * mult_now() * dev) / (64'd256 * n);
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            if (t < 1) t = 1;
            return t[31:0];
        endfunction

        function int unsigned slot(int unsigned age);
            return (head + NHIST - 1 - age) % NHIST;
        endfunction

        // note one accepted input word
        function void note_word(logic [11:0] lvl, bit last, logic [31:0] tm, bit en);
            int unsigned p, ci;
            logic [31:0] d, s;
            logic [28:0] flux, cand;
            logic [31:0] thr, ctime, elapsed;
            logic [63:0] old, st;
            bit peak, gap_ok;
            t_onset_word w;
            p = band_pos % NBANDS;
            if (prior_ok && lvl > prior_lvl[p]) begin
                d = 32'(lvl) - 32'(prior_lvl[p]);
                s = 32'(acc) + d * d;
                acc = (s > 32'(FLUX_CAP)) ? FLUX_CAP : s[28:0];
            end
            prior_lvl[p] = lvl;
            band_pos = (p + 1) % NBANDS;
            if (!last) return;
            flux = acc;
            acc = '0;
            band_pos = 0;
            prior_ok = 1;
            thr = threshold_now();
            if (fill >= NHIST) begin
                old = 64'(flux_hist[head]);
                flux_tot = flux_tot - old;
                flux_sq_tot = flux_sq_tot - old * old;
            end else begin
                fill++;
            end
            flux_hist[head] = flux;
            time_hist[head] = tm;
            en_hist[head]   = en;
            flux_tot = flux_tot + 64'(flux);
            flux_sq_tot = flux_sq_tot + 64'(flux) * 64'(flux);
            head = (head + 1) % NHIST;
            ci = slot(2);
            cand = flux_hist[ci];
            ctime = time_hist[ci];
            peak = 1;
            for (int a = 0; a <= 4; a++)
                if (a != 2 && flux_hist[slot(a)] >= cand) peak = 0;
            elapsed = ctime - last_onset;
            gap_ok = !last_onset_ok || elapsed >= 32'(min_gap);
            w.ready = (fill >= NHIST / 2);
            w.found = 0; w.strength = '0; w.gap = '0; w.onset_time = '0;
            w.cand_flux = cand; w.threshold = thr;
            if (w.ready && en_hist[ci] && peak && gap_ok && 32'(cand) > thr) begin
                st = (64'(32'(cand) - thr) * 64'd256) / 64'(thr);
                if (st < 26) st = 26;
                if (st > 256) st = 256;
                w.found = 1;
                w.strength = st[8:0];
                w.gap = last_onset_ok ? elapsed : 32'd0;
                w.onset_time = ctime;
                last_onset = ctime;
                last_onset_ok = 1;
            end
            expected_q.push_back(w);
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_word(t_onset_word got);
            t_onset_word e;
            if (expected_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.ready !== e.ready) begin
                $error("history_ready exp %0d got %0d", e.ready, got.ready); errors++;
            end
            if (got.found !== e.found) begin
                $error("onset_found exp %0d got %0d", e.found, got.found); errors++;
            end
            if (got.strength !== e.strength) begin
                $error("strength_q8 exp %0d got %0d", e.strength, got.strength); errors++;
            end
            if (got.gap !== e.gap) begin
                $error("gap_ms exp %0d got %0d", e.gap, got.gap); errors++;
            end
            if (got.onset_time !== e.onset_time) begin
                $error("onset_time_ms exp %0d got %0d", e.onset_time, got.onset_time);
                errors++;
            end
            if (got.cand_flux !== e.cand_flux) begin
                $error("candidate_flux exp %0d got %0d", e.cand_flux, got.cand_flux);
                errors++;
            end
            if (got.threshold !== e.threshold) begin
                $error("flux_threshold exp %0d got %0d", e.threshold, got.threshold);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [sfod_pkg::LevelW-1:0]         i_band_level;
    logic                                i_last_band;
    logic [sfod_pkg::TimeW-1:0]          i_frame_time_ms;
    logic                                i_detect_enable;
    logic                                o_valid;
    logic                                i_stall;
    logic                                o_history_ready;
    logic                                o_onset_found;
    logic [sfod_pkg::StrW-1:0]           o_strength_q8;
    logic [sfod_pkg::TimeW-1:0]          o_gap_ms;
    logic [sfod_pkg::TimeW-1:0]          o_onset_time_ms;
    logic [sfod_pkg::FluxW-1:0]          o_candidate_flux;
    logic [sfod_pkg::TimeW-1:0]          o_flux_threshold;
    logic                                i_cfg_we;
    logic [sfod_pkg::CfgIdxW-1:0]        i_cfg_idx;
    logic [sfod_pkg::CfgDataW-1:0]       i_cfg_data;

    t_onset_scoreboard sb;
    bit                calm;
    int                hold_cycles;
    int                words_sent;
    logic [31:0]       frame_clock;

    spectral_flux_onset_detector_top dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: stall bursts and the long hold-off
    initial begin
        int burst;
        burst = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // result sampling
    always @(posedge i_clk) begin
        t_onset_word got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.ready = o_history_ready;
            got.found = o_onset_found;
            got.strength = o_strength_q8;
            got.gap = o_gap_ms;
            got.onset_time = o_onset_time_ms;
            got.cand_flux = o_candidate_flux;
            got.threshold = o_flux_threshold;
            sb.check_word(got);
        end
    end

    // offer one band word, called and returning at a falling edge
    task automatic put_word(logic [11:0] lvl, bit last, logic [31:0] tm, bit en);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_band_level <= lvl;
        i_last_band <= last;
        i_frame_time_ms <= tm;
        i_detect_enable <= en;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(lvl, last, tm, en);
        words_sent++;
        @(negedge i_clk);
    endtask

    // wait for the block to drain, then write both registers
    task automatic set_config(logic [sfod_pkg::CfgDataW-1:0] sens_data,
                              logic [sfod_pkg::CfgDataW-1:0] gap_data);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= sfod_pkg::CFG_SENS;
        i_cfg_data <= sens_data;
        @(negedge i_clk);
        sb.write_reg(sfod_pkg::CFG_SENS, sens_data);
        i_cfg_idx <= sfod_pkg::CFG_MIN_INT;
        i_cfg_data <= gap_data;
        @(negedge i_clk);
        sb.write_reg(sfod_pkg::CFG_MIN_INT, gap_data);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // one random frame: mostly quiet, sometimes loud, rarely overlong and saturating
    task automatic send_frame();
        int kind, len;
        bit en;
        logic [11:0] lvl;
        kind = $urandom_range(0, 99);
        if (kind < 10) len = $urandom_range(1, 3);
        else if (kind < 65) len = $urandom_range(4, 12);
        else if (kind < 95) len = NBANDS;
        else len = $urandom_range(33, 70);
        en = ($urandom_range(0, 6) != 0);
        if ($urandom_range(0, 19) == 0) frame_clock = $urandom;
        else frame_clock = frame_clock + $urandom_range(8, 40);
        for (int i = 0; i < len; i++) begin
            if (kind >= 95) lvl = 12'hFFF;
            else if (kind % 7 == 0) lvl = 12'($urandom_range(1500, 4095));
            else if (kind % 11 == 0) lvl = 12'($urandom);
            else lvl = 12'($urandom_range(0, 300));
            put_word(lvl, i == len - 1, (i == len - 1) ? frame_clock : $urandom, en);
        end
    endtask

    // stimulus
    initial begin
        sb = new();
        calm = 0;
        hold_cycles = 0;
        words_sent = 0;
        frame_clock = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_band_level = '0;
        i_last_band = 1'b0;
        i_frame_time_ms = '0;
        i_detect_enable = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = sfod_pkg::CFG_SENS;
        i_cfg_data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: first frame, extremes, one-band frame, short frames
        set_config(16'hFF80, 16'd0);
        put_word(12'hFFF, 0, 32'hFFFF_FFFF, 1);
        put_word(12'h000, 0, 32'h0, 0);
        put_word(12'hFFF, 1, 32'h0, 1);
        put_word(12'h000, 0, 32'h0, 1);
        put_word(12'hFFF, 0, 32'h0, 1);
        put_word(12'h000, 1, 32'hFFFF_FFFF, 0);
        put_word(12'hFFF, 1, 32'd5, 1);
        put_word(12'h000, 1, 32'd6, 1);
        put_word(12'h800, 1, 32'h8000_0000, 1);
        for (int i = 0; i < 5; i++) put_word(12'(i * 1000), i == 4, 32'h7FFF_FFFF, 1);
        for (int i = 0; i < 4; i++) put_word(12'h001, i == 3, 32'h0000_0010, 0);

        // random phases over several register settings, the last one without idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(16'd1, 16'd0);
                1: set_config(16'd100, 16'hFFFF);
                2: set_config(16'h007F, 16'($urandom_range(0, 120)));
                3: set_config(16'($urandom), 16'($urandom_range(0, 60)));
                4: set_config(16'($urandom_range(1, 100)), 16'd0);
                default: begin
                    set_config(16'd40, 16'd20);
                    calm = 1;
                end
            endcase
            // long receiver hold-off while frames keep coming
            if (ph == 0) hold_cycles = 2500;
            while (words_sent < 20 + (ph + 1) * 320) send_frame();
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/sfod_pkg.sv
src/sfod_mul.sv
src/sfod_div.sv
src/sfod_isqrt.sv
src/spectral_flux_onset_detector_top.sv
tb/tb_spectral_flux_onset_detector_top.sv
